// File: hw/rtl/zsc_pkg.sv
// Shared constants and controller/datapath interface types for the zero-sum subarray counter.
package zsc_pkg;

    localparam int ZSC_MAX_LEN_DEF     = 1024;
    localparam int ZSC_TABLE_SLOTS_DEF = 2048;
    localparam int ZSC_VALUE_BITS_DEF  = 16;

    localparam int TOTAL_W  = 20;                     // zero_sum_count width
    localparam int M_DATA_W = ((TOTAL_W + 7) / 8) * 8;
    localparam int EPOCH_W  = 8;                      // sequence tag kept in each table slot

    localparam logic [TOTAL_W-1:0] TOTAL_MAX = '1;

    typedef struct packed {
        logic load;       // input beat taken: latch sample, update prefix and index
        logic probe;      // read one table slot
        logic check;      // compare read slot, write back, update total when done
        logic zero_bump;  // prefix is zero: use the dedicated counter
        logic out_load;   // load the output register
        logic seq_clear;  // end of sequence: restart sums, advance epoch
        logic clr_write;  // clearing pass: wipe one slot
    } zsc_cmd_t;

    typedef struct packed {
        logic in_over;    // index has reached MAX_LEN
        logic in_zero;    // prefix after this sample is zero
        logic hash_fast;  // slot hash is available without the serial unit
        logic hash_done;
        logic check_done; // probe found the key, a free slot, or ran out of slots
        logic last_item;
        logic epoch_max;
        logic clr_last;
        logic out_free;
    } zsc_sts_t;

endpackage

// File: hw/rtl/zsc_slot_hash.sv
// Home-slot hash of a prefix value: mask for power-of-two tables, reciprocal remainder otherwise.
module zsc_slot_hash import zsc_pkg::*; #(
    parameter int PREFIX_W    = 26,
    parameter int TABLE_SLOTS = ZSC_TABLE_SLOTS_DEF
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           start,
    input  logic [PREFIX_W-1:0]            key,
    output logic [$clog2(TABLE_SLOTS)-1:0] slot,
    output logic                           done
);

    localparam int SLOT_W = $clog2(TABLE_SLOTS);

    function automatic logic [63:0] mix(input logic [PREFIX_W-1:0] k);
        logic [63:0] k64;
        k64 = {{(64 - PREFIX_W){k[PREFIX_W-1]}}, k};
        return k64 ^ (k64 >> 11) ^ (k64 >> 23);
    endfunction

    // 2^n mod TABLE_SLOTS, for constants
    function automatic logic [63:0] pow2_mod(input int n);
        logic [63:0] r;
        r = 64'd1;
        for (int i = 0; i < n; i++) begin
            r = (r << 1) % 64'(TABLE_SLOTS);
        end
        return r;
    endfunction

    if ((TABLE_SLOTS & (TABLE_SLOTS - 1)) == 0) begin : g_mask
        logic [63:0] mixed;
        assign mixed = mix(key);
        assign slot  = mixed[SLOT_W-1:0];
        assign done  = 1'b1 | start | aclk | aresetn;
    end else begin : g_recip
        // Low PREFIX_W bits of the mixed word are split into bytes, each weighted
        // by 2^(8i) mod slots. Bits above PREFIX_W depend only on the sign and add
        // a fixed term. The small sum is reduced by a reciprocal multiply.
        // Start latches the word; fold, multiply and subtract are then registered in that order.
        localparam int          N_DIG   = (PREFIX_W + 7) / 8;
        localparam int          DIG_W   = 8 * N_DIG;
        localparam logic [63:0] SLOTS64 = 64'(TABLE_SLOTS);
        localparam logic [63:0] ONES    = '1;
        localparam logic [63:0] HI_MIX  = (ONES ^ (ONES >> 11) ^ (ONES >> 23)) >> PREFIX_W;
        localparam logic [63:0] NEG_ADD = ((HI_MIX % SLOTS64) * pow2_mod(PREFIX_W)) % SLOTS64;
        localparam logic [63:0] ACC_MAX = 64'(N_DIG) * 64'd255 * (SLOTS64 - 64'd1)
                                        + (SLOTS64 - 64'd1);
        localparam int          ACC_W   = $clog2(ACC_MAX + 64'd1);
        localparam int          SH      = ACC_W + SLOT_W;
        localparam int          PROD_W  = 2 * ACC_W + 1;
        localparam int          Q_W     = PROD_W - SH;
        localparam logic [63:0] RECIP   = ((64'd1 << SH) + SLOTS64 - 64'd1) / SLOTS64;

        logic [DIG_W-1:0]            bits_reg;
        logic                        neg_reg;
        logic [1:0]                  step_reg;
        logic [ACC_W-1:0]            acc_reg;
        logic [PROD_W-1:0]           prod_reg;
        logic [SLOT_W-1:0]           rem_reg;
        logic [63:0]                 mixed;
        logic [N_DIG-1:0][ACC_W-1:0] term;
        logic [ACC_W-1:0]            acc_sum;
        logic [Q_W-1:0]              quo;
        logic [ACC_W-1:0]            rem_full;

        assign mixed = mix(key);

        for (genvar i = 0; i < N_DIG; i++) begin : g_dig
            localparam logic [63:0] WGT = pow2_mod(8 * i);
            assign term[i] = ACC_W'(bits_reg[8*i +: 8]) * ACC_W'(WGT);
        end

        always_comb begin
            acc_sum = neg_reg ? ACC_W'(NEG_ADD) : '0;
            for (int i = 0; i < N_DIG; i++) begin
                acc_sum = acc_sum + term[i];
            end
        end

        // quotient is exact for any sum below 2^ACC_W
        assign quo      = prod_reg[PROD_W-1 -: Q_W];
        assign rem_full = acc_reg - ACC_W'(quo) * ACC_W'(TABLE_SLOTS);

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                step_reg <= '0;
            end else if (start) begin
                step_reg <= 2'd3;
            end else if (step_reg != '0) begin
                step_reg <= step_reg - 2'd1;
            end
        end

        always_ff @(posedge aclk) begin
            if (start) begin
                bits_reg <= DIG_W'(mixed[PREFIX_W-1:0]);
                neg_reg  <= key[PREFIX_W-1];
            end
            if (step_reg == 2'd3) begin
                acc_reg <= acc_sum;
            end
            if (step_reg == 2'd2) begin
                prod_reg <= PROD_W'(acc_reg) * PROD_W'(RECIP);
            end
            if (step_reg == 2'd1) begin
                rem_reg <= rem_full[SLOT_W-1:0];
            end
        end

        assign slot = rem_reg;
        assign done = (step_reg == '0);
    end

endmodule

// File: hw/rtl/zsc_datapath.sv
// Datapath: prefix sum, prefix count table with linear probing, running total, output register.
module zsc_datapath import zsc_pkg::*; #(
    parameter int MAX_LEN     = ZSC_MAX_LEN_DEF,
    parameter int TABLE_SLOTS = ZSC_TABLE_SLOTS_DEF,
    parameter int VALUE_BITS  = ZSC_VALUE_BITS_DEF,
    parameter int S_DATA_W    = ((VALUE_BITS + 7) / 8) * 8
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  zsc_cmd_t            cmd,
    output zsc_sts_t            sts,
    input  logic [S_DATA_W-1:0] s_tdata,
    input  logic                s_tlast,
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [M_DATA_W-1:0] m_tdata,
    output logic                m_tlast,
    output logic                m_tuser
);

    localparam int PW     = VALUE_BITS + $clog2(MAX_LEN);
    localparam int SLOT_W = $clog2(TABLE_SLOTS);
    localparam int TRY_W  = $clog2(TABLE_SLOTS + 1);
    localparam int IDX_W  = $clog2(MAX_LEN + 1);
    localparam int CNT_W  = $clog2(MAX_LEN + 2);
    localparam int SUM_W  = ((CNT_W > TOTAL_W) ? CNT_W : TOTAL_W) + 1;
    localparam int WORD_W = EPOCH_W + PW + CNT_W;

    // table word: {epoch, key, count}
    logic [WORD_W-1:0] mem [TABLE_SLOTS];

    logic [PW-1:0]      prefix_reg;
    logic [TOTAL_W-1:0] total_reg;
    logic [IDX_W-1:0]   idx_reg;
    logic [CNT_W-1:0]   zc_reg;
    logic [EPOCH_W-1:0] epoch_reg;
    logic [SLOT_W-1:0]  clr_addr_reg;
    logic [TRY_W-1:0]   tries_reg;
    logic [SLOT_W-1:0]  slot_reg;
    logic [WORD_W-1:0]  rd_word_reg;
    logic               last_reg;
    logic               over_reg;
    logic               m_valid_reg;
    logic [TOTAL_W-1:0] m_count_reg;
    logic               m_last_reg;
    logic               m_user_reg;

    logic [VALUE_BITS-1:0] sample;
    logic [PW-1:0]         sample_ext;
    logic [PW-1:0]         prefix_next;
    logic [PW-1:0]         hash_key;
    logic [SLOT_W-1:0]     hash_slot;
    logic                  hash_done;
    logic [SLOT_W-1:0]     probe_addr;
    logic [EPOCH_W-1:0]    rd_epoch;
    logic [PW-1:0]         rd_key;
    logic [CNT_W-1:0]      rd_cnt;
    logic                  slot_empty;
    logic                  key_hit;
    logic [TRY_W-1:0]      tries_next;
    logic                  exhausted;
    logic                  check_done;
    logic [CNT_W-1:0]      seen;
    logic [SUM_W-1:0]      sum_full;
    logic [TOTAL_W-1:0]    total_next;
    logic [SLOT_W-1:0]     slot_next;
    logic                  mem_we;
    logic [SLOT_W-1:0]     mem_waddr;
    logic [WORD_W-1:0]     mem_wdata;
    logic                  out_free;

    assign sample      = s_tdata[VALUE_BITS-1:0];
    assign sample_ext  = {{(PW - VALUE_BITS){sample[VALUE_BITS-1]}}, sample};
    assign prefix_next = prefix_reg + sample_ext;
    assign hash_key    = cmd.load ? prefix_next : prefix_reg;

    zsc_slot_hash #(
        .PREFIX_W    (PW),
        .TABLE_SLOTS (TABLE_SLOTS)
    ) u_hash (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (cmd.load),
        .key     (hash_key),
        .slot    (hash_slot),
        .done    (hash_done)
    );

    // first probe goes to the home slot, later ones walk forward
    assign probe_addr = (tries_reg == '0) ? hash_slot : slot_reg;

    assign rd_epoch   = rd_word_reg[WORD_W-1 -: EPOCH_W];
    assign rd_key     = rd_word_reg[CNT_W +: PW];
    assign rd_cnt     = rd_word_reg[CNT_W-1:0];
    assign slot_empty = (rd_epoch != epoch_reg);
    assign key_hit    = !slot_empty && (rd_key == prefix_reg);
    assign tries_next = tries_reg + TRY_W'(1);
    assign exhausted  = (tries_next == TRY_W'(TABLE_SLOTS));
    assign check_done = slot_empty || key_hit || exhausted;
    assign slot_next  = (slot_reg == SLOT_W'(TABLE_SLOTS - 1)) ? '0 : slot_reg + SLOT_W'(1);

    always_comb begin
        if (cmd.zero_bump) begin
            seen = zc_reg;
        end else if (key_hit) begin
            seen = rd_cnt;
        end else begin
            seen = '0;
        end
    end

    assign sum_full   = SUM_W'(total_reg) + SUM_W'(seen);
    assign total_next = (sum_full > SUM_W'(TOTAL_MAX)) ? TOTAL_MAX : sum_full[TOTAL_W-1:0];

    assign mem_we    = cmd.clr_write || (cmd.check && (slot_empty || key_hit));
    assign mem_waddr = cmd.clr_write ? clr_addr_reg : slot_reg;
    assign mem_wdata = cmd.clr_write ? '0
                     : {epoch_reg, prefix_reg, slot_empty ? CNT_W'(1) : rd_cnt + CNT_W'(1)};

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[mem_waddr] <= mem_wdata;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.probe) begin
            rd_word_reg <= mem[probe_addr];
        end
    end

    assign out_free = !m_valid_reg || m_tready;

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prefix_reg   <= '0;
            total_reg    <= '0;
            idx_reg      <= '0;
            zc_reg       <= CNT_W'(1);
            epoch_reg    <= EPOCH_W'(1);
            clr_addr_reg <= '0;
            tries_reg    <= '0;
            m_valid_reg  <= 1'b0;
        end else begin
            if (cmd.load) begin
                tries_reg <= '0;
                if (!sts.in_over) begin
                    prefix_reg <= prefix_next;
                    idx_reg    <= idx_reg + IDX_W'(1);
                end
            end
            if (cmd.zero_bump) begin
                zc_reg    <= zc_reg + CNT_W'(1);
                total_reg <= total_next;
            end
            if (cmd.check) begin
                if (check_done) begin
                    total_reg <= total_next;
                end else begin
                    tries_reg <= tries_next;
                end
            end
            if (cmd.seq_clear) begin
                prefix_reg <= '0;
                total_reg  <= '0;
                idx_reg    <= '0;
                zc_reg     <= CNT_W'(1);
                epoch_reg  <= (epoch_reg == '1) ? EPOCH_W'(1) : epoch_reg + EPOCH_W'(1);
            end
            if (cmd.clr_write) begin
                clr_addr_reg <= sts.clr_last ? '0 : clr_addr_reg + SLOT_W'(1);
            end
            if (cmd.out_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // payload
    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            last_reg <= s_tlast;
            over_reg <= sts.in_over;
        end
        if (cmd.probe) begin
            slot_reg <= probe_addr;
        end else if (cmd.check && !check_done) begin
            slot_reg <= slot_next;
        end
        if (cmd.out_load) begin
            m_count_reg <= total_reg;
            m_last_reg  <= last_reg;
            m_user_reg  <= over_reg;
        end
    end

    always_comb begin
        sts            = '0;
        sts.in_over    = (idx_reg == IDX_W'(MAX_LEN));
        sts.in_zero    = (prefix_next == '0);
        sts.hash_fast  = ((TABLE_SLOTS & (TABLE_SLOTS - 1)) == 0);
        sts.hash_done  = hash_done;
        sts.check_done = check_done;
        sts.last_item  = last_reg;
        sts.epoch_max  = (epoch_reg == '1);
        sts.clr_last   = (clr_addr_reg == SLOT_W'(TABLE_SLOTS - 1));
        sts.out_free   = out_free;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = M_DATA_W'(m_count_reg);
    assign m_tlast  = m_last_reg;
    assign m_tuser  = m_user_reg;

endmodule

// File: hw/rtl/zsc_ctrl.sv
// Controller FSM: table clear; per beat accept, hash, probe, compare or zero, output.
module zsc_ctrl import zsc_pkg::*; (
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     s_tvalid,
    output logic     s_tready,
    input  zsc_sts_t sts,
    output zsc_cmd_t cmd
);

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_HASH,
        S_PROBE,
        S_CHECK,
        S_ZERO,
        S_OUT
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            S_CLEAR: begin
                cmd.clr_write = 1'b1;
                if (sts.clr_last) begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE: begin
                if (s_tvalid) begin
                    cmd.load = 1'b1;
                    if (sts.in_over) begin
                        state_next = S_OUT;
                    end else if (sts.in_zero) begin
                        state_next = S_ZERO;
                    end else if (sts.hash_fast) begin
                        state_next = S_PROBE;
                    end else begin
                        state_next = S_HASH;
                    end
                end
            end
            S_HASH: begin
                if (sts.hash_done) begin
                    state_next = S_PROBE;
                end
            end
            S_PROBE: begin
                cmd.probe  = 1'b1;
                state_next = S_CHECK;
            end
            S_CHECK: begin
                cmd.check  = 1'b1;
                state_next = sts.check_done ? S_OUT : S_PROBE;
            end
            S_ZERO: begin
                cmd.zero_bump = 1'b1;
                state_next    = S_OUT;
            end
            S_OUT: begin
                if (sts.out_free) begin
                    cmd.out_load  = 1'b1;
                    cmd.seq_clear = sts.last_item;
                    state_next    = (sts.last_item && sts.epoch_max) ? S_CLEAR : S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_CLEAR;
        end else begin
            state_reg <= state_next;
        end
    end

    assign s_tready = (state_reg == S_IDLE);

endmodule

// File: hw/rtl/zero_sum_subarray_counter.sv
// Top level of the zero-sum subarray counter: controller plus datapath.
//
//  Channel  Dir  tdata                              tlast            tuser
//  s_       in   [VALUE_BITS-1:0] sample_value      end_of_sequence  -
//  m_       out  [19:0] zero_sum_count, pad zeros   final_result     length_exceeded
//
// With a power-of-two table a beat passes accept, probe, compare and output;
// each further slot probed repeats probe and compare (linear probing through
// the single-port table memory). A zero prefix uses the zero count instead, an
// element past MAX_LEN goes straight to output. Other table sizes add a hash
// wait for the home-slot remainder (byte fold, reciprocal multiply, subtract).
// After reset, and after every 255th finished sequence, a clearing pass wipes the
// whole table with s_tready low; other sequences end at once because every
// slot carries a sequence tag.
// A result waiting in the output register does not block the next input beat;
// only the following result waits for m_tready.
module zero_sum_subarray_counter import zsc_pkg::*; #(
    parameter int MAX_LEN     = ZSC_MAX_LEN_DEF,
    parameter int TABLE_SLOTS = ZSC_TABLE_SLOTS_DEF,
    parameter int VALUE_BITS  = ZSC_VALUE_BITS_DEF
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 s_tvalid,
    output logic                                 s_tready,
    input  logic [((VALUE_BITS + 7) / 8) * 8-1:0] s_tdata,  // [VALUE_BITS-1:0] sample_value
    input  logic                                 s_tlast,
    output logic                                 m_tvalid,
    input  logic                                 m_tready,
    output logic [M_DATA_W-1:0]                  m_tdata,   // [19:0] zero_sum_count
    output logic                                 m_tlast,
    output logic                                 m_tuser    // [0] length_exceeded
);

    localparam int S_DATA_W = ((VALUE_BITS + 7) / 8) * 8;

    zsc_cmd_t cmd;
    zsc_sts_t sts;

    // sequencing: one beat at a time
    zsc_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    // sums, count table and the output register
    zsc_datapath #(
        .MAX_LEN     (MAX_LEN),
        .TABLE_SLOTS (TABLE_SLOTS),
        .VALUE_BITS  (VALUE_BITS),
        .S_DATA_W    (S_DATA_W)
    ) u_dp (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cmd      (cmd),
        .sts      (sts),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .m_tuser  (m_tuser)
    );

endmodule

// File: hw/rtl/zsc_checker.sv
// Port-level checks for the zero-sum subarray counter, bound to the top level.
module zsc_checker import zsc_pkg::*; (
    input logic                aclk,
    input logic                aresetn,
    input logic                s_tvalid,
    input logic                s_tready,
    input logic                m_tvalid,
    input logic                m_tready,
    input logic [M_DATA_W-1:0] m_tdata,
    input logic                m_tlast,
    input logic                m_tuser
);

    // reset empties the output register
    a_reset_clears_out: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result beat valid right after reset");

    // a stalled result beat holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=>
            m_tvalid && $stable(m_tdata) && $stable(m_tlast) && $stable(m_tuser))
        else $error("stalled result beat changed");

    // one beat in flight: input closes right after a beat is taken
    a_one_in_flight: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input accepted while previous beat still in work");

    // padding above the count stays zero
    a_pad_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata >> TOTAL_W) == '0)
        else $error("result padding bits not zero");

endmodule

bind zero_sum_subarray_counter zsc_checker u_zsc_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast),
    .m_tuser  (m_tuser)
);

// File: bench/zero_sum_subarray_counter_tb.sv
// Self-checking stream testbench for the zero-sum subarray counter.
`timescale 1ns / 100ps

module zero_sum_subarray_counter_tb;
    import zsc_pkg::*;

    localparam int MAX_LEN     = ZSC_MAX_LEN_DEF;
    localparam int TABLE_SLOTS = ZSC_TABLE_SLOTS_DEF;
    localparam int VALUE_BITS  = ZSC_VALUE_BITS_DEF;
    localparam int S_DATA_W    = ((VALUE_BITS + 7) / 8) * 8;
    localparam int CYCLE_LIMIT = 600000;
    localparam int DRAIN_WAIT  = 64;
    localparam int HOLD_OFF    = 400;

    typedef struct {
        logic [VALUE_BITS-1:0] value;
        logic                  last;
        bit                    pause;   // wait for every result before sending
    } sample_beat_t;

    typedef struct packed {
        logic [TOTAL_W-1:0] count;
        logic               is_final;
        logic               over_len;
    } count_beat_t;

    typedef enum logic [1:0] {RX_OPEN, RX_MOSTLY_READY, RX_MOSTLY_BUSY, RX_TOGGLE} rx_mode_t;

    logic                aclk     = 1'b0;
    logic                aresetn  = 1'b0;
    logic                s_tvalid = 1'b0;
    logic                s_tready;
    logic [S_DATA_W-1:0] s_tdata  = '0;
    logic                s_tlast  = 1'b0;
    logic                m_tvalid;
    logic                m_tready = 1'b0;
    logic [M_DATA_W-1:0] m_tdata;
    logic                m_tlast;
    logic                m_tuser;

    zero_sum_subarray_counter #(
        .MAX_LEN    (MAX_LEN),
        .TABLE_SLOTS(TABLE_SLOTS),
        .VALUE_BITS (VALUE_BITS)
    ) u_dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .s_tlast (s_tlast),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata),
        .m_tlast (m_tlast),
        .m_tuser (m_tuser)
    );

    always #5 aclk = ~aclk;

    sample_beat_t pending_samples[$];
    count_beat_t  predicted_counts[$];
    int           fail_count   = 0;
    int           results_seen = 0;
    int           cycle_count  = 0;
    int           beat_total   = 0;
    int           seq_total    = 0;

    // ---------------- prediction: prefix sums with a linear-probe table ----------------
    longint             run_prefix;
    logic [TOTAL_W-1:0] run_total;
    int unsigned        elem_count;
    int unsigned        zero_hits;
    longint             slot_key  [TABLE_SLOTS];
    int unsigned        slot_cnt  [TABLE_SLOTS];
    bit                 slot_used [TABLE_SLOTS];

    function automatic void restart_sequence();
        run_prefix = 0;
        run_total  = '0;
        elem_count = 0;
        zero_hits  = 1;
        foreach (slot_used[i]) slot_used[i] = 1'b0;
    endfunction

    // Count of earlier equal prefixes, then record one more.
    function automatic int unsigned prefix_bump(input longint key);
        logic [63:0] k;
        int unsigned idx;
        int unsigned c;
        if (key == 0) begin
            c = zero_hits;
            zero_hits++;
            return c;
        end
        k   = key;
        idx = int'((k ^ (k >> 11) ^ (k >> 23)) % TABLE_SLOTS);
        for (int t = 0; t < TABLE_SLOTS; t++) begin
            if (!slot_used[idx]) begin
                slot_used[idx] = 1'b1;
                slot_key[idx]  = key;
                slot_cnt[idx]  = 1;
                return 0;
            end
            if (slot_key[idx] == key) begin
                c = slot_cnt[idx];
                slot_cnt[idx] = c + 1;
                return c;
            end
            idx = (idx + 1) % TABLE_SLOTS;
        end
        return 0;   // table full: prefix not stored
    endfunction

    function automatic count_beat_t count_zero_sums(input logic [VALUE_BITS-1:0] raw,
                                                    input logic last_in);
        count_beat_t r;
        int unsigned seen;
        longint      sum_new;
        r.over_len = (elem_count >= MAX_LEN);
        if (!r.over_len) begin
            run_prefix += longint'($signed(raw));
            elem_count++;
            seen    = prefix_bump(run_prefix);
            sum_new = longint'(run_total) + longint'(seen);
            run_total = (sum_new > longint'(TOTAL_MAX)) ? TOTAL_MAX : sum_new[TOTAL_W-1:0];
        end
        r.count    = run_total;
        r.is_final = last_in;
        if (last_in) restart_sequence();
        return r;
    endfunction

    // ---------------- stimulus generation ----------------
    function automatic logic [VALUE_BITS-1:0] pick_sample(input longint pfx);
        int unsigned roll;
        roll = $urandom_range(0, 99);
        if (roll < 45) return VALUE_BITS'(int'($urandom_range(0, 6)) - 3);
        if (roll < 65) return VALUE_BITS'($urandom);
        if (roll < 75) return $urandom_range(0, 1) ? 16'h7FFF : 16'h8000;
        // pull the prefix back to zero when one value can do it
        if (pfx >= -32767 && pfx <= 32767) return VALUE_BITS'(-pfx);
        return VALUE_BITS'(int'($urandom_range(0, 6)) - 3);
    endfunction

    task automatic queue_beat(input logic [VALUE_BITS-1:0] v, input logic last,
                              input bit pause);
        pending_samples.push_back('{value: v, last: last, pause: pause});
        beat_total++;
        if (last) seq_total++;
    endtask

    task automatic queue_sequence(input int len, input bit pause_first);
        longint pfx;
        logic [VALUE_BITS-1:0] v;
        pfx = 0;
        for (int i = 0; i < len; i++) begin
            v = pick_sample(pfx);
            pfx += longint'($signed(v));
            queue_beat(v, i == len - 1, pause_first && i == 0);
        end
    endtask

    // ---------------- sender: bursts with random gaps ----------------
    int           burst_left;
    int           gap_left;
    sample_beat_t next_beat;

    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid   <= 1'b0;
            s_tdata    <= '0;
            s_tlast    <= 1'b0;
            burst_left <= 4;
            gap_left   <= 0;
        end else begin
            if (s_tvalid && s_tready)
                predicted_counts.push_back(count_zero_sums(s_tdata[VALUE_BITS-1:0], s_tlast));
            if (!s_tvalid || s_tready) begin
                if (gap_left != 0) begin
                    gap_left <= gap_left - 1;
                    s_tvalid <= 1'b0;
                end else if (pending_samples.size() != 0 &&
                             !(pending_samples[0].pause && predicted_counts.size() != 0)) begin
                    next_beat = pending_samples.pop_front();
                    s_tvalid <= 1'b1;
                    s_tdata  <= S_DATA_W'(next_beat.value);
                    s_tlast  <= next_beat.last;
                    if (burst_left <= 1) begin
                        burst_left <= $urandom_range(1, 24);
                        gap_left   <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
                    end else begin
                        burst_left <= burst_left - 1;
                    end
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // ---------------- receiver: stall modes plus long hold-offs ----------------
    rx_mode_t rx_mode;
    int       mode_left;
    int       hold_left;
    int       next_hold_at;

    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready     <= 1'b0;
            rx_mode      <= RX_OPEN;
            mode_left    <= 0;
            hold_left    <= 0;
            next_hold_at <= 40;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
            m_tready  <= 1'b0;
        end else if (results_seen >= next_hold_at) begin
            // sender keeps offering while this lasts, so the input backs up
            hold_left    <= HOLD_OFF;
            next_hold_at <= next_hold_at + 700;
            m_tready     <= 1'b0;
        end else begin
            if (mode_left == 0) begin
                rx_mode   <= rx_mode_t'($urandom_range(0, 3));
                mode_left <= $urandom_range(20, 200);
            end else begin
                mode_left <= mode_left - 1;
            end
            case (rx_mode)
                RX_OPEN:         m_tready <= 1'b1;
                RX_MOSTLY_READY: m_tready <= ($urandom_range(0, 3) != 0);
                RX_MOSTLY_BUSY:  m_tready <= ($urandom_range(0, 3) == 0);
                default:         m_tready <= cycle_count[1];
            endcase
        end
    end

    // ---------------- result checker ----------------
    count_beat_t want;

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            results_seen <= results_seen + 1;
            if (predicted_counts.size() == 0) begin
                $error("result beat with no expectation: count %0d", m_tdata[TOTAL_W-1:0]);
                fail_count++;
            end else begin
                want = predicted_counts.pop_front();
                if (m_tdata[TOTAL_W-1:0] !== want.count) begin
                    $error("zero_sum_count: expected %0d, got %0d",
                           want.count, m_tdata[TOTAL_W-1:0]);
                    fail_count++;
                end
                if (m_tlast !== want.is_final) begin
                    $error("final_result: expected %0b, got %0b", want.is_final, m_tlast);
                    fail_count++;
                end
                if (m_tuser !== want.over_len) begin
                    $error("length_exceeded: expected %0b, got %0b", want.over_len, m_tuser);
                    fail_count++;
                end
            end
        end
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("FAIL");
            $finish;
        end
    end

    // ---------------- test sequence ----------------
    initial begin
        bit long_done;
        int len;
        long_done = 1'b0;
        restart_sequence();

        // directed: extremes, repeats, cancelling pairs, lone items
        queue_beat(16'h0000, 1'b1, 1'b0);
        queue_beat(16'h7FFF, 1'b0, 1'b0);
        queue_beat(16'h8000, 1'b0, 1'b0);
        queue_beat(16'h0001, 1'b0, 1'b0);
        queue_beat(16'h0000, 1'b1, 1'b0);
        queue_beat(16'h0005, 1'b0, 1'b0);
        queue_beat(16'hFFFB, 1'b0, 1'b0);
        queue_beat(16'h0005, 1'b0, 1'b0);
        queue_beat(16'hFFFB, 1'b1, 1'b0);
        queue_beat(16'h8000, 1'b0, 1'b0);
        queue_beat(16'h8000, 1'b0, 1'b0);
        queue_beat(16'h7FFF, 1'b0, 1'b0);
        queue_beat(16'h7FFF, 1'b0, 1'b0);
        queue_beat(16'h0002, 1'b1, 1'b0);
        queue_beat(16'h8000, 1'b1, 1'b0);
        queue_beat(16'h7FFF, 1'b1, 1'b0);
        for (int i = 0; i < 4; i++) queue_beat(16'h0000, i == 3, 1'b0);
        queue_beat(16'h0001, 1'b0, 1'b1);
        queue_beat(16'hFFFF, 1'b0, 1'b0);
        queue_beat(16'h0002, 1'b0, 1'b0);
        queue_beat(16'hFFFE, 1'b1, 1'b0);

        // random: mostly short sequences, enough to wrap the sequence tag,
        // plus one run past MAX_LEN whose over-length tail carries the end mark
        while (seq_total < 270 || beat_total < 1650) begin
            if (!long_done && seq_total >= 150) begin
                queue_sequence(MAX_LEN + 6, 1'b1);
                long_done = 1'b1;
            end
            case ($urandom_range(0, 19)) inside
                0:       len = $urandom_range(6, 12);
                [1:9]:   len = 1;
                default: len = $urandom_range(2, 4);
            endcase
            queue_sequence(len, $urandom_range(0, 40) == 0);
        end

        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;

        do @(posedge aclk);
        while (pending_samples.size() != 0 || s_tvalid || predicted_counts.size() != 0);
        repeat (DRAIN_WAIT) @(posedge aclk);

        if (predicted_counts.size() != 0) begin
            $error("%0d expected results never arrived", predicted_counts.size());
            fail_count++;
        end
        if (fail_count == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule

// File: files.f
hw/rtl/zsc_pkg.sv
hw/rtl/zsc_slot_hash.sv
hw/rtl/zsc_datapath.sv
hw/rtl/zsc_ctrl.sv
hw/rtl/zero_sum_subarray_counter.sv
hw/rtl/zsc_checker.sv
bench/zero_sum_subarray_counter_tb.sv
